// ===== design/nsq_pkg.sv =====
// Shared types and constants for the nine-slice quad generator.
`timescale 1ns / 1ps

package nsq_pkg;

  localparam int unsigned NUM_QUADS = 9;
  localparam int unsigned QIDX_W    = 4;
  localparam logic [QIDX_W-1:0] LAST_QUAD = 4'd8;

  // Slice grid is 3 by 3
  localparam logic [1:0] LAST_COL = 2'd2;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned SIZE_W   = 15;
  localparam int unsigned MARGIN_W = 14;
  localparam int unsigned TEXEL_W  = 12;
  localparam int unsigned TEX_W    = 17;
  localparam int unsigned COLOR_W  = 32;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = MARGIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_LEFT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_RIGHT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_TOP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_BOTTOM = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_LEFT      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_TOP       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 4'd7;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Edges along one axis: screen offsets from the origin (first edge is
  // always zero) and texture edges in Q12.4, wrapped to 17 bits.
  typedef struct packed {
    logic [3:1][SIZE_W-1:0] scr;
    logic [3:0][TEX_W-1:0]  tx;
  } nsq_axis_t;

  typedef struct packed {
    logic [POS_W-1:0]   dx;
    logic [POS_W-1:0]   dy;
    nsq_axis_t          ax;
    nsq_axis_t          ay;
    logic [COLOR_W-1:0] tint;
    logic               degen;
  } nsq_entry_t;

endpackage

// ===== design/nsq_front.sv =====
// Front end: configuration registers and per-request edge computation.
`timescale 1ns / 1ps

module nsq_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [nsq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nsq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic signed [nsq_pkg::POS_W-1:0]   in_dest_x,
  input  logic signed [nsq_pkg::POS_W-1:0]   in_dest_y,
  input  logic [nsq_pkg::SIZE_W-1:0]         in_box_width,
  input  logic [nsq_pkg::SIZE_W-1:0]         in_box_height,
  input  logic [nsq_pkg::COLOR_W-1:0]        in_tint,
  output nsq_pkg::nsq_entry_t                entry
);

  logic [nsq_pkg::MARGIN_W-1:0] margin_left_r, margin_right_r;
  logic [nsq_pkg::MARGIN_W-1:0] margin_top_r, margin_bottom_r;
  logic [nsq_pkg::TEXEL_W-1:0]  tex_left_r, tex_top_r, tex_width_r, tex_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_left_r   <= '0;
      margin_right_r  <= '0;
      margin_top_r    <= '0;
      margin_bottom_r <= '0;
      tex_left_r      <= '0;
      tex_top_r       <= '0;
      tex_width_r     <= '0;
      tex_height_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nsq_pkg::CFG_MARGIN_LEFT:   margin_left_r   <= cfg_wdata;
        nsq_pkg::CFG_MARGIN_RIGHT:  margin_right_r  <= cfg_wdata;
        nsq_pkg::CFG_MARGIN_TOP:    margin_top_r    <= cfg_wdata;
        nsq_pkg::CFG_MARGIN_BOTTOM: margin_bottom_r <= cfg_wdata;
        nsq_pkg::CFG_TEX_LEFT:      tex_left_r      <= cfg_wdata[nsq_pkg::TEXEL_W-1:0];
        nsq_pkg::CFG_TEX_TOP:       tex_top_r       <= cfg_wdata[nsq_pkg::TEXEL_W-1:0];
        nsq_pkg::CFG_TEX_WIDTH:     tex_width_r     <= cfg_wdata[nsq_pkg::TEXEL_W-1:0];
        nsq_pkg::CFG_TEX_HEIGHT:    tex_height_r    <= cfg_wdata[nsq_pkg::TEXEL_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic nsq_pkg::nsq_axis_t split_axis(
    input logic [nsq_pkg::SIZE_W-1:0]   size,
    input logic [nsq_pkg::MARGIN_W-1:0] m0,
    input logic [nsq_pkg::MARGIN_W-1:0] m1,
    input logic [nsq_pkg::TEXEL_W-1:0]  org,
    input logic [nsq_pkg::TEXEL_W-1:0]  tsz
  );
    nsq_pkg::nsq_axis_t        a;
    logic [nsq_pkg::SIZE_W-1:0] msum;
    logic [nsq_pkg::TEX_W-1:0]  torg;
    logic [nsq_pkg::TEX_W-1:0]  tsize;
    logic [nsq_pkg::TEX_W-1:0]  tm0;
    logic [nsq_pkg::TEX_W-1:0]  tm1;
    // Two 14-bit margins never overflow 15 bits, so the test is exact
    msum  = {1'b0, m0} + {1'b0, m1};
    torg  = {1'b0, org, 4'b0000};
    tsize = {1'b0, tsz, 4'b0000};
    tm0   = {3'b000, m0};
    tm1   = {3'b000, m1};
    a.scr[3] = size;
    if (size < msum) begin
      a.scr[1] = {1'b0, size[nsq_pkg::SIZE_W-1:1]};
      a.scr[2] = {1'b0, size[nsq_pkg::SIZE_W-1:1]};
    end else begin
      a.scr[1] = {1'b0, m0};
      a.scr[2] = size - {1'b0, m1};
    end
    a.tx[0] = torg;
    a.tx[1] = torg + tm0;
    a.tx[2] = torg + tsize - tm1;
    a.tx[3] = torg + tsize;
    return a;
  endfunction

  always_comb begin
    entry.dx    = in_dest_x;
    entry.dy    = in_dest_y;
    entry.tint  = in_tint;
    entry.ax    = split_axis(in_box_width, margin_left_r, margin_right_r,
                             tex_left_r, tex_width_r);
    entry.ay    = split_axis(in_box_height, margin_top_r, margin_bottom_r,
                             tex_top_r, tex_height_r);
    entry.degen = (in_box_width == '0) || (in_box_height == '0) ||
                  (tex_width_r == '0);
  end

endmodule

// ===== design/nsq_queue.sv =====
// Short queue of classified requests between front and back end.
`timescale 1ns / 1ps

module nsq_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nsq_pkg::nsq_entry_t din,
  input  logic                pop,
  output nsq_pkg::nsq_entry_t dout,
  output logic                empty,
  output logic                full
);

  nsq_pkg::nsq_entry_t               slot_r [nsq_pkg::Q_DEPTH];
  logic [nsq_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [nsq_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [nsq_pkg::Q_CNT_W-1:0]       count_r, count_nxt;

  localparam logic [nsq_pkg::Q_PTR_W-1:0] PTR_LAST = nsq_pkg::Q_PTR_W'(nsq_pkg::Q_DEPTH - 1);
  localparam logic [nsq_pkg::Q_CNT_W-1:0] CNT_FULL = nsq_pkg::Q_CNT_W'(nsq_pkg::Q_DEPTH);

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_FULL);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== design/nsq_back.sv =====
// Back end: steps through the nine slices of the head request, one a cycle.
`timescale 1ns / 1ps

module nsq_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nsq_pkg::nsq_entry_t                head,
  input  logic                               head_valid,
  output logic                               pop,
  output logic                               out_valid,
  output logic [nsq_pkg::QIDX_W-1:0]         out_quad_index,
  output logic signed [nsq_pkg::POS_W-1:0]   out_dst_left,
  output logic signed [nsq_pkg::POS_W-1:0]   out_dst_upper,
  output logic [nsq_pkg::SIZE_W-1:0]         out_dst_span_x,
  output logic [nsq_pkg::SIZE_W-1:0]         out_dst_span_y,
  output logic signed [nsq_pkg::TEX_W-1:0]   out_src_left,
  output logic signed [nsq_pkg::TEX_W-1:0]   out_src_upper,
  output logic signed [nsq_pkg::TEX_W-1:0]   out_src_span_x,
  output logic signed [nsq_pkg::TEX_W-1:0]   out_src_span_y,
  output logic [nsq_pkg::COLOR_W-1:0]        out_quad_color,
  output logic                               out_last
);

  logic [1:0]                  col_r, col_nxt, row_r, row_nxt;
  logic [nsq_pkg::QIDX_W-1:0]  idx_r, idx_nxt;
  logic                        valid_r;

  logic [nsq_pkg::POS_W-1:0]   dst_left_r, dst_upper_r;
  logic [nsq_pkg::SIZE_W-1:0]  span_x_r, span_y_r;
  logic [nsq_pkg::TEX_W-1:0]   src_left_r, src_upper_r, src_span_x_r, src_span_y_r;
  logic [nsq_pkg::COLOR_W-1:0] color_r;
  logic [nsq_pkg::QIDX_W-1:0]  qidx_r;
  logic                        last_r;

  logic [3:0][nsq_pkg::SIZE_W-1:0] xe, ye;
  logic [1:0]                      col_p1, row_p1;
  logic [nsq_pkg::SIZE_W-1:0]      sw, sh;
  logic                            suppress;

  assign xe     = {head.ax.scr[3], head.ax.scr[2], head.ax.scr[1], {nsq_pkg::SIZE_W{1'b0}}};
  assign ye     = {head.ay.scr[3], head.ay.scr[2], head.ay.scr[1], {nsq_pkg::SIZE_W{1'b0}}};
  assign col_p1 = col_r + 2'd1;
  assign row_p1 = row_r + 2'd1;
  assign sw     = xe[col_p1] - xe[col_r];
  assign sh     = ye[row_p1] - ye[row_r];
  // Spans are never negative here, so "not positive" means zero
  assign suppress = head.degen || (sw == '0) || (sh == '0);
  assign pop      = head_valid && (idx_r == nsq_pkg::LAST_QUAD);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    idx_nxt = idx_r;
    if (head_valid) begin
      if (pop) begin
        col_nxt = '0;
        row_nxt = '0;
        idx_nxt = '0;
      end else if (col_r == nsq_pkg::LAST_COL) begin
        col_nxt = '0;
        row_nxt = row_r + 2'd1;
        idx_nxt = idx_r + 1'b1;
      end else begin
        col_nxt = col_r + 2'd1;
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      idx_r   <= idx_nxt;
      valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid) begin
      qidx_r  <= idx_r;
      last_r  <= (idx_r == nsq_pkg::LAST_QUAD);
      color_r <= head.tint;
      if (suppress) begin
        dst_left_r   <= '0;
        dst_upper_r  <= '0;
        span_x_r     <= '0;
        span_y_r     <= '0;
        src_left_r   <= '0;
        src_upper_r  <= '0;
        src_span_x_r <= '0;
        src_span_y_r <= '0;
      end else begin
        dst_left_r   <= head.dx + {1'b0, xe[col_r]};
        dst_upper_r  <= head.dy + {1'b0, ye[row_r]};
        span_x_r     <= sw;
        span_y_r     <= sh;
        src_left_r   <= head.ax.tx[col_r];
        src_upper_r  <= head.ay.tx[row_r];
        src_span_x_r <= head.ax.tx[col_p1] - head.ax.tx[col_r];
        src_span_y_r <= head.ay.tx[row_p1] - head.ay.tx[row_r];
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_quad_index = qidx_r;
  assign out_dst_left   = $signed(dst_left_r);
  assign out_dst_upper  = $signed(dst_upper_r);
  assign out_dst_span_x = span_x_r;
  assign out_dst_span_y = span_y_r;
  assign out_src_left   = $signed(src_left_r);
  assign out_src_upper  = $signed(src_upper_r);
  assign out_src_span_x = $signed(src_span_x_r);
  assign out_src_span_y = $signed(src_span_y_r);
  assign out_quad_color = color_r;
  assign out_last       = last_r;

endmodule

// ===== design/nine_slice_quad_generator_core.sv =====
// Top level of the nine-slice quad generator: front end, queue, back end.
// An item accepted into an empty queue is written into a queue slot, then the
// back end registers its first quad on the result ports; the other eight
// follow back to back. Throughput: the back-end slice sequencer drives one
// quad per cycle while the queue holds an item; a two-entry queue lets the
// next item in. Reset (rst_n low, synchronous) clears the config registers,
// the sequencer and the queue; the receiver cannot stall the output.
`timescale 1ns / 1ps

module nine_slice_quad_generator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [nsq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nsq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [nsq_pkg::POS_W-1:0]   in_dest_x,
  input  logic signed [nsq_pkg::POS_W-1:0]   in_dest_y,
  input  logic [nsq_pkg::SIZE_W-1:0]         in_box_width,
  input  logic [nsq_pkg::SIZE_W-1:0]         in_box_height,
  input  logic [nsq_pkg::COLOR_W-1:0]        in_tint,
  output logic                               out_valid,
  output logic [nsq_pkg::QIDX_W-1:0]         out_quad_index,
  output logic signed [nsq_pkg::POS_W-1:0]   out_dst_left,
  output logic signed [nsq_pkg::POS_W-1:0]   out_dst_upper,
  output logic [nsq_pkg::SIZE_W-1:0]         out_dst_span_x,
  output logic [nsq_pkg::SIZE_W-1:0]         out_dst_span_y,
  output logic signed [nsq_pkg::TEX_W-1:0]   out_src_left,
  output logic signed [nsq_pkg::TEX_W-1:0]   out_src_upper,
  output logic signed [nsq_pkg::TEX_W-1:0]   out_src_span_x,
  output logic signed [nsq_pkg::TEX_W-1:0]   out_src_span_y,
  output logic [nsq_pkg::COLOR_W-1:0]        out_quad_color,
  output logic                               out_last
);

  nsq_pkg::nsq_entry_t front_entry, head_entry;
  logic                q_full, q_empty, q_pop, accept;

  assign busy   = q_full;
  assign accept = start && !q_full;

  nsq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_dest_x     (in_dest_x),
    .in_dest_y     (in_dest_y),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .in_tint       (in_tint),
    .entry         (front_entry)
  );

  nsq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (front_entry),
    .pop   (q_pop),
    .dout  (head_entry),
    .empty (q_empty),
    .full  (q_full)
  );

  nsq_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head_entry),
    .head_valid     (!q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_quad_index (out_quad_index),
    .out_dst_left   (out_dst_left),
    .out_dst_upper  (out_dst_upper),
    .out_dst_span_x (out_dst_span_x),
    .out_dst_span_y (out_dst_span_y),
    .out_src_left   (out_src_left),
    .out_src_upper  (out_src_upper),
    .out_src_span_x (out_src_span_x),
    .out_src_span_y (out_src_span_y),
    .out_quad_color (out_quad_color),
    .out_last       (out_last)
  );

endmodule

// ===== design/nsq_checker.sv =====
// Port-level assertions for the nine-slice quad generator, bound to the top.
`timescale 1ns / 1ps

module nsq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [nsq_pkg::QIDX_W-1:0] out_quad_index
);

  // Quads of one item come out on consecutive cycles
  a_quads_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_quad_index != nsq_pkg::LAST_QUAD) |=> out_valid)
    else $error("quad stream broke before the last slice");

  a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_quad_index != nsq_pkg::LAST_QUAD) |=>
      out_quad_index == $past(out_quad_index) + 4'd1)
    else $error("slice index did not advance by one");

  // Quiet output and no item taken the edge before means the queue is empty:
  // an item taken now is written into the queue, then the back-end output registers show slice zero
  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !out_valid && !$past(start && !busy) |->
      ##2 out_valid && (out_quad_index == '0))
    else $error("item accepted while idle did not start at slice zero");

  a_busy_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !busy)
    else $error("outputs active right after reset");

endmodule

bind nine_slice_quad_generator_core nsq_checker u_nsq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_quad_index (out_quad_index)
);
